### src/haversine_great_circle_distance_assert.svh
// ----------------------------------------------------------------------------
// Haversine distance assertion macros
// Shared property templates for the distance pipeline checks.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HVD_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("haversine distance assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HVD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("haversine distance assertion failed");

`endif

### src/hvd_pkg.sv
// ----------------------------------------------------------------------------
// Haversine distance package
// Field widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hvd_pkg;

   localparam int ANGLE_FRAC_BITS   = 20;
   localparam int CORDIC_ITERATIONS = 24;

   localparam int LAT_W    = 28;
   localparam int LON_W    = 29;
   localparam int RADIUS_W = 24;
   localparam int DIST_W   = 26;

   // Integer square root of a Q60 radicand: one result bit per step.
   localparam int SQ_W     = 62;
   localparam int SQ_STEPS = 31;
   localparam int ROOT_W   = 31;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6523904;
   localparam logic [DIST_W-1:0]   DIST_MAX     = 26'd52707178;
   localparam logic [30:0]         DEG2RAD_Q36  = 31'd1199381129;
   localparam logic [29:0]         GAIN_INV     = 30'd652032874;
   localparam logic [30:0]         Q30_ONE      = 31'h4000_0000;

   // atan(2^-i) in Q30 radians, truncated.
   function automatic logic [31:0] atan_q30(input int i);
      case (i)
         0:       return 32'h3243F6A8;
         1:       return 32'h1DAC6705;
         2:       return 32'h0FADBAFC;
         3:       return 32'h07F56EA6;
         4:       return 32'h03FEAB76;
         5:       return 32'h01FFD55B;
         6:       return 32'h00FFFAAA;
         7:       return 32'h007FFF55;
         8:       return 32'h003FFFEA;
         9:       return 32'h001FFFFD;
         10:      return 32'h000FFFFF;
         11:      return 32'h0007FFFF;
         12:      return 32'h0003FFFF;
         13:      return 32'h0001FFFF;
         14:      return 32'h0000FFFF;
         15:      return 32'h00007FFF;
         16:      return 32'h00003FFF;
         17:      return 32'h00001FFF;
         18:      return 32'h00000FFF;
         19:      return 32'h000007FF;
         20:      return 32'h000003FF;
         21:      return 32'h000001FF;
         22:      return 32'h000000FF;
         23:      return 32'h0000007F;
         24:      return 32'h0000003F;
         25:      return 32'h0000001F;
         26:      return 32'h0000000F;
         27:      return 32'h00000008;
         28:      return 32'h00000004;
         29:      return 32'h00000002;
         30:      return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

endpackage

### src/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage, with a side tag.
// ----------------------------------------------------------------------------
module hvd_isqrt #(
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [hvd_pkg::SQ_W-1:0]    in_radicand,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [hvd_pkg::ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int W     = hvd_pkg::SQ_W;
   localparam int STEPS = hvd_pkg::SQ_STEPS;

   logic [W-1:0]     rem_ff [0:STEPS-1];
   logic [W-1:0]     rem_in [0:STEPS-1];
   logic [W-1:0]     acc_ff [0:STEPS-1];
   logic [W-1:0]     acc_in [0:STEPS-1];
   logic [TAG_W-1:0] tag_ff [0:STEPS-1];
   logic [STEPS-1:0] vld_ff;
   logic [STEPS-1:0] vld_in;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
      logic [W-1:0] rem_prev;
      logic [W-1:0] acc_prev;
      logic [W-1:0] trial;
      logic         take;
      if (k == 0) begin : g_first
         assign rem_prev = in_radicand;
         assign acc_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign acc_prev = acc_ff[k-1];
      end
      assign trial     = acc_prev + BIT;
      assign take      = (rem_prev >= trial);
      assign rem_in[k] = take ? rem_prev - trial : rem_prev;
      assign acc_in[k] = take ? (acc_prev >> 1) + BIT : acc_prev >> 1;
   end

   assign vld_in = {vld_ff[STEPS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
         end
         tag_ff[0] <= in_tag;
         for (int k = 1; k < STEPS; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = hvd_pkg::ROOT_W'(acc_ff[STEPS-1]);
   assign out_tag   = tag_ff[STEPS-1];

endmodule

### src/haversine_great_circle_distance.sv
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Every stage is registered; the CORDIC and square-root stages are fully unrolled.
// Throughput is one beat per cycle while the skid stage is empty.
// Reset is synchronous; it clears valid bits and loads the radius with 6371 km.
// ----------------------------------------------------------------------------
`include "haversine_great_circle_distance_assert.svh"

module haversine_great_circle_distance #(
   parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITERATIONS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hvd_pkg::LAT_W-1:0]    req_first_latitude,
   input  logic signed [hvd_pkg::LON_W-1:0]    req_first_longitude,
   input  logic signed [hvd_pkg::LAT_W-1:0]    req_second_latitude,
   input  logic signed [hvd_pkg::LON_W-1:0]    req_second_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hvd_pkg::DIST_W-1:0]          rsp_distance,
   input  logic                                csr_write_enable,
   input  logic [hvd_pkg::RADIUS_W-1:0]        csr_write_data
);

   localparam int N      = CORDIC_ITERATIONS;
   localparam int F      = hvd_pkg::ANGLE_FRAC_BITS;
   localparam int T_W    = F + 10;
   localparam int R_W    = F + 8;
   localparam int ZP_W   = R_W + 31;
   localparam int X_W    = 34;
   localparam int Z_W    = 33;
   localparam int SUM_W  = 35;
   localparam int ZC_W   = 31;
   localparam int RP_W   = hvd_pkg::RADIUS_W + ZC_W;
   localparam int FRONT  = N + 7;
   localparam int SQ_W   = hvd_pkg::SQ_W;
   localparam int ROOT_W = hvd_pkg::ROOT_W;

   localparam logic signed [33:0]      FULL_S  = 34'(64'd360 << F);
   localparam logic [T_W-1:0]          QTR1    = T_W'(64'd180 << F);
   localparam logic [T_W-1:0]          QTR2    = T_W'(64'd360 << F);
   localparam logic [T_W-1:0]          QTR3    = T_W'(64'd540 << F);
   localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(hvd_pkg::Q30_ONE);

   // Reduce an angle difference to [0, 360) degrees.
   function automatic logic [T_W-1:0] wrap_turn(input logic signed [31:0] a);
      logic signed [33:0] w;
      w = 34'(a);
      if (w[33]) w = w + FULL_S;
      if (w[33]) w = w + FULL_S;
      if (w >= FULL_S) w = w - FULL_S;
      return T_W'(w);
   endfunction

   logic                         en;
   logic                         skid_ff, skid_in;
   logic [hvd_pkg::DIST_W-1:0]   skid_distance_ff, skid_distance_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hvd_pkg::DIST_W-1:0]   rsp_distance_ff, rsp_distance_in;
   logic [hvd_pkg::RADIUS_W-1:0] radius_ff;

   logic [FRONT-1:0]             vf_ff, vf_in;
   logic [T_W-1:0]               t_ff [0:3];
   logic [T_W-1:0]               t_in [0:3];
   logic [1:0]                   quad_ff [0:3];
   logic [1:0]                   quad_in [0:3];
   logic [R_W-1:0]               rem_ff [0:3];
   logic [R_W-1:0]               rem_in [0:3];
   logic [ZP_W-1:0]              zp [0:3];

   logic signed [X_W-1:0]        rx_ff [0:N][0:3];
   logic signed [X_W-1:0]        rx_in [0:N][0:3];
   logic signed [X_W-1:0]        ry_ff [0:N][0:3];
   logic signed [X_W-1:0]        ry_in [0:N][0:3];
   logic signed [Z_W-1:0]        rz_ff [0:N][0:3];
   logic signed [Z_W-1:0]        rz_in [0:N][0:3];
   logic [1:0]                   rq_ff [0:N][0:3];

   logic signed [X_W-1:0]        sin_v [0:3];
   logic signed [X_W-1:0]        cos_v [0:3];
   logic signed [31:0]           u_ff, v_ff, c1_ff, c2_ff;
   logic signed [31:0]           u_in, v_in, c1_in, c2_in;
   logic signed [63:0]           uu_ff, vv_ff, cc_ff;
   logic signed [63:0]           uu_in, vv_in, cc_in;
   logic signed [31:0]           w_val, v2_val;
   logic signed [32:0]           us_ff, us_in;
   logic signed [63:0]           wv_ff, wv_in;
   logic signed [SUM_W-1:0]      sum_raw;
   logic [30:0]                  sum_ff, sum_in;

   logic                         sq1_valid, sq2_valid;
   logic [ROOT_W-1:0]            sq1_root, sq2_root, sq2_tag;
   logic                         vm_ff, va_ff;
   logic [ROOT_W-1:0]            m_ff, m_in, ma_ff;
   logic [SQ_W-1:0]              mm_ff, mm_in, a_ff, a_in;

   logic [N-1:0]                 vvld_ff, vvld_in;
   logic signed [X_W-1:0]        vx_ff [0:N-1];
   logic signed [X_W-1:0]        vx_in [0:N-1];
   logic signed [X_W-1:0]        vy_ff [0:N-1];
   logic signed [X_W-1:0]        vy_in [0:N-1];
   logic signed [Z_W-1:0]        vz_ff [0:N-1];
   logic signed [Z_W-1:0]        vz_in [0:N-1];

   logic [ZC_W-1:0]              zc;
   logic                         vr_ff;
   logic [RP_W-1:0]              rp_ff, rp_in;
   logic [RP_W:0]                rnd;
   logic [hvd_pkg::DIST_W-1:0]   dist_new;

   // The whole pipeline moves together; it stops only while the skid stage holds a beat.
   assign en        = !skid_ff;
   assign req_ready = en;
   assign vf_in     = {vf_ff[FRONT-2:0], req_valid};

   // Angle reduction. Differences are read in half-degree units, so the CORDIC sees
   // half angles; the latitudes are doubled to keep their full angle.
   always_comb begin
      t_in[0] = wrap_turn(32'(req_second_latitude) - 32'(req_first_latitude));
      t_in[1] = wrap_turn(32'(req_second_longitude) - 32'(req_first_longitude));
      t_in[2] = wrap_turn(32'(req_first_latitude)) << 1;
      t_in[3] = wrap_turn(32'(req_second_latitude)) << 1;
   end

   // Quadrant split, then conversion of the residue to Q30 radians.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (t_ff[l] >= QTR3) begin
            quad_in[l] = 2'd3;
            rem_in[l]  = R_W'(t_ff[l] - QTR3);
         end else if (t_ff[l] >= QTR2) begin
            quad_in[l] = 2'd2;
            rem_in[l]  = R_W'(t_ff[l] - QTR2);
         end else if (t_ff[l] >= QTR1) begin
            quad_in[l] = 2'd1;
            rem_in[l]  = R_W'(t_ff[l] - QTR1);
         end else begin
            quad_in[l] = 2'd0;
            rem_in[l]  = R_W'(t_ff[l]);
         end
         zp[l] = ZP_W'(rem_ff[l]) * ZP_W'(hvd_pkg::DEG2RAD_Q36);
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_seed
      assign rx_in[0][l] = X_W'(hvd_pkg::GAIN_INV);
      assign ry_in[0][l] = '0;
      assign rz_in[0][l] = Z_W'(zp[l] >> (7 + F));
   end

   // Rotation CORDIC, one iteration per stage, four lanes.
   for (genvar k = 1; k <= N; k++) begin : g_rot
      localparam logic signed [Z_W-1:0] AT = Z_W'(hvd_pkg::atan_q30(k - 1));
      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic signed [X_W-1:0] xs, ys;
         logic                  neg;
         assign xs  = rx_ff[k-1][l] >>> (k - 1);
         assign ys  = ry_ff[k-1][l] >>> (k - 1);
         assign neg = rz_ff[k-1][l][Z_W-1];
         assign rx_in[k][l] = neg ? rx_ff[k-1][l] + ys : rx_ff[k-1][l] - ys;
         assign ry_in[k][l] = neg ? ry_ff[k-1][l] - xs : ry_ff[k-1][l] + xs;
         assign rz_in[k][l] = neg ? rz_ff[k-1][l] + AT : rz_ff[k-1][l] - AT;
      end
   end

   // Quadrant fold back to sine and cosine.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         case (rq_ff[N][l])
            2'd0: begin
               sin_v[l] = ry_ff[N][l];
               cos_v[l] = rx_ff[N][l];
            end
            2'd1: begin
               sin_v[l] = rx_ff[N][l];
               cos_v[l] = -ry_ff[N][l];
            end
            2'd2: begin
               sin_v[l] = -ry_ff[N][l];
               cos_v[l] = -rx_ff[N][l];
            end
            default: begin
               sin_v[l] = -rx_ff[N][l];
               cos_v[l] = ry_ff[N][l];
            end
         endcase
      end
      u_in  = 32'(sin_v[0]);
      v_in  = 32'(sin_v[1]);
      c1_in = 32'(cos_v[2]);
      c2_in = 32'(cos_v[3]);
   end

   // Haversine sum u*u + cos1*cos2*v*v, clamped to [0, 1].
   always_comb begin
      uu_in   = u_ff * u_ff;
      vv_in   = v_ff * v_ff;
      cc_in   = c1_ff * c2_ff;
      w_val   = 32'(cc_ff >>> 30);
      v2_val  = 32'(vv_ff >>> 30);
      wv_in   = w_val * v2_val;
      us_in   = 33'(uu_ff >>> 30);
      sum_raw = SUM_W'(us_ff) + SUM_W'(wv_ff >>> 30);
      if (sum_raw[SUM_W-1]) begin
         sum_in = '0;
      end else if (sum_raw > SUM_ONE) begin
         sum_in = hvd_pkg::Q30_ONE;
      end else begin
         sum_in = 31'(sum_raw);
      end
   end

   hvd_isqrt #(
      .TAG_W (1)
   ) u_sqrt_sum (
      .clock       (clock),
      .reset       (reset),
      .enable      (en),
      .in_valid    (vf_ff[FRONT-1]),
      .in_radicand (SQ_W'(sum_ff) << 30),
      .in_tag      (1'b0),
      .out_valid   (sq1_valid),
      .out_root    (sq1_root),
      .out_tag     ()
   );

   // The arcsine runs as atan2(m, sqrt(1 - m*m)).
   always_comb begin
      m_in  = (sq1_root > ROOT_W'(hvd_pkg::Q30_ONE)) ? ROOT_W'(hvd_pkg::Q30_ONE) : sq1_root;
      mm_in = SQ_W'(m_in) * SQ_W'(m_in);
      a_in  = (SQ_W'(1) << 60) - mm_ff;
   end

   hvd_isqrt #(
      .TAG_W (ROOT_W)
   ) u_sqrt_cos (
      .clock       (clock),
      .reset       (reset),
      .enable      (en),
      .in_valid    (va_ff),
      .in_radicand (a_ff),
      .in_tag      (ma_ff),
      .out_valid   (sq2_valid),
      .out_root    (sq2_root),
      .out_tag     (sq2_tag)
   );

   // Vectoring CORDIC drives y to zero and collects the angle.
   for (genvar k = 0; k < N; k++) begin : g_vec
      localparam logic signed [Z_W-1:0] AT = Z_W'(hvd_pkg::atan_q30(k));
      logic signed [X_W-1:0] xp, yp, xs, ys;
      logic signed [Z_W-1:0] zpv;
      if (k == 0) begin : g_first
         assign xp  = X_W'(sq2_root);
         assign yp  = X_W'(sq2_tag);
         assign zpv = '0;
      end else begin : g_next
         assign xp  = vx_ff[k-1];
         assign yp  = vy_ff[k-1];
         assign zpv = vz_ff[k-1];
      end
      assign xs = xp >>> k;
      assign ys = yp >>> k;
      assign vx_in[k] = yp[X_W-1] ? xp - ys : xp + ys;
      assign vy_in[k] = yp[X_W-1] ? yp + xs : yp - xs;
      assign vz_in[k] = yp[X_W-1] ? zpv - AT : zpv + AT;
   end

   generate
      if (N > 1) begin : g_vv_chain
         assign vvld_in = {vvld_ff[N-2:0], sq2_valid};
      end else begin : g_vv_single
         assign vvld_in = sq2_valid;
      end
   endgenerate

   // Scale by twice the radius, round and saturate.
   always_comb begin
      zc       = vz_ff[N-1][Z_W-1] ? '0 : ZC_W'(vz_ff[N-1]);
      rp_in    = RP_W'(radius_ff) * RP_W'(zc);
      rnd      = (RP_W + 1)'(rp_ff) + ((RP_W + 1)'(1) << 28);
      dist_new = ((rnd >> 29) > (RP_W + 1)'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX
               : hvd_pkg::DIST_W'(rnd >> 29);
   end

   // Output register with a one-beat skid stage behind it.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_distance_in  = rsp_distance_ff;
      skid_in          = skid_ff;
      skid_distance_in = skid_distance_ff;
      if (skid_ff) begin
         if (rsp_ready) begin
            rsp_valid_in    = 1'b1;
            rsp_distance_in = skid_distance_ff;
            skid_in         = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in    = vr_ff;
         rsp_distance_in = dist_new;
      end else if (vr_ff) begin
         skid_in          = 1'b1;
         skid_distance_in = dist_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= hvd_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
         skid_ff      <= 1'b0;
         vf_ff        <= '0;
         vm_ff        <= 1'b0;
         va_ff        <= 1'b0;
         vvld_ff      <= '0;
         vr_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radius_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         skid_ff      <= skid_in;
         if (en) begin
            vf_ff   <= vf_in;
            vm_ff   <= sq1_valid;
            va_ff   <= vm_ff;
            vvld_ff <= vvld_in;
            vr_ff   <= vvld_ff[N-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff  <= rsp_distance_in;
      skid_distance_ff <= skid_distance_in;
      if (en) begin
         for (int l = 0; l < 4; l++) begin
            t_ff[l]     <= t_in[l];
            quad_ff[l]  <= quad_in[l];
            rem_ff[l]   <= rem_in[l];
            rq_ff[0][l] <= quad_ff[l];
         end
         for (int k = 0; k <= N; k++) begin
            for (int l = 0; l < 4; l++) begin
               rx_ff[k][l] <= rx_in[k][l];
               ry_ff[k][l] <= ry_in[k][l];
               rz_ff[k][l] <= rz_in[k][l];
            end
         end
         for (int k = 1; k <= N; k++) begin
            for (int l = 0; l < 4; l++) begin
               rq_ff[k][l] <= rq_ff[k-1][l];
            end
         end
         u_ff   <= u_in;
         v_ff   <= v_in;
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         uu_ff  <= uu_in;
         vv_ff  <= vv_in;
         cc_ff  <= cc_in;
         us_ff  <= us_in;
         wv_ff  <= wv_in;
         sum_ff <= sum_in;
         m_ff   <= m_in;
         mm_ff  <= mm_in;
         ma_ff  <= m_ff;
         a_ff   <= a_in;
         for (int k = 0; k < N; k++) begin
            vx_ff[k] <= vx_in[k];
            vy_ff[k] <= vy_in[k];
            vz_ff[k] <= vz_in[k];
         end
         rp_ff <= rp_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   `HVD_ASSERT_IMPLY(a_skid_has_out, clock, reset, skid_ff, rsp_valid_ff)
   `HVD_ASSERT_NEXT(a_skid_only_on_stall, clock, reset, !skid_ff && !(rsp_valid_ff && !rsp_ready), !skid_ff)
   `HVD_ASSERT_IMPLY(a_dist_in_range, clock, reset, rsp_valid_ff, rsp_distance_ff <= hvd_pkg::DIST_MAX)
   `HVD_ASSERT_NEXT(a_stall_holds_tail, clock, reset, skid_ff, $stable(vr_ff) && $stable(rp_ff))

endmodule
